// ===== rtl/core/nsr_pkg.sv =====
// Package for the Newton-Raphson square root: state encoding and the fixed result width.
`timescale 1ns / 1ps

package nsr_pkg;

  // Result field width, fixed by the result format
  localparam int unsigned RootWidth = 32;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,  // waiting for a request
    ST_DIV,   // one quotient bit per cycle
    ST_STEP,  // Newton update and convergence test
    ST_OUT    // hand the root to the output register
  } nsr_state_e;

endpackage

// ===== rtl/core/nsr_in_if.sv =====
// Request channel interface: valid/ready handshake carrying the radicand.
`timescale 1ns / 1ps

interface nsr_in_if #(
  parameter int unsigned InputWidth = 32
) ();

  logic                  valid;
  logic                  ready;
  logic [InputWidth-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);

endinterface

// ===== rtl/core/nsr_out_if.sv =====
// Result channel interface: valid/ready handshake carrying the Q16.16 root.
`timescale 1ns / 1ps

interface nsr_out_if ();

  logic                           valid;
  logic                           ready;
  logic [nsr_pkg::RootWidth-1:0]  root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);

endinterface

// ===== rtl/core/newton_square_root.sv =====
// Newton-Raphson square root, unsigned integer in, unsigned fixed point out.
//
//  channel | dir | payload            | handshake
//  --------+-----+--------------------+-------------------------------
//  in_i    | in  | radicand [IW-1:0]  | valid/ready, taken when both high
//  out_o   | out | root [31:0]        | valid/ready, taken when both high
//
// Each Newton step runs a restoring divider over N = IW + 2*FB quotient bits,
// one bit per cycle, then the update in ST_STEP.
// A request runs at most MAX_ITERATIONS steps; radicands 0 and 1 skip the
// divider and go straight to ST_OUT.
// Reset clears the sequencer and the output valid; data registers are not reset.
// A waiting result sits in the output register; the core holds in ST_OUT only
// while that register is still full.
`timescale 1ns / 1ps

module newton_square_root #(
  parameter int unsigned INPUT_WIDTH    = 32,
  parameter int unsigned FRACTION_BITS  = 16,
  parameter int unsigned MAX_ITERATIONS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nsr_in_if.sink    in_i,
  nsr_out_if.source out_o
);

  import nsr_pkg::*;

  // Guess width, numerator/quotient width, width for saturation compare, counter widths
  localparam int unsigned GuessW = INPUT_WIDTH + FRACTION_BITS;
  localparam int unsigned NumW   = INPUT_WIDTH + 2 * FRACTION_BITS;
  localparam int unsigned ExtW   = (GuessW > RootWidth) ? GuessW : RootWidth;
  localparam int unsigned CntW   = $clog2(NumW);
  localparam int unsigned IterW  = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;

  nsr_state_e state_q, state_d;

  logic [INPUT_WIDTH-1:0] rad_q;
  logic [GuessW-1:0]      guess_q;
  logic [GuessW-1:0]      rem_q;
  logic [NumW-1:0]        nq_q;      // dividend shifts out, quotient shifts in
  logic [CntW-1:0]        cnt_q;
  logic [IterW-1:0]       iter_q;
  logic                   out_valid_q;
  logic [RootWidth-1:0]   root_q;

  logic                   in_fire;
  logic                   out_fire;
  logic                   rad_small;
  logic [GuessW:0]        rem_shift;
  logic                   div_ge;
  logic [GuessW:0]        rem_sub;
  logic [NumW:0]          step_sum;
  logic [NumW-1:0]        next_guess;
  logic                   converged;
  logic                   iter_last;
  logic                   out_free;
  logic [ExtW-1:0]        guess_ext;
  logic [RootWidth-1:0]   root_sat;

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_fire  = out_o.valid && out_o.ready;
  assign rad_small = in_i.radicand < INPUT_WIDTH'(2);
  assign out_free  = !out_valid_q || out_o.ready;

  // Divider datapath: shift one dividend bit in, compare and subtract
  assign rem_shift = {rem_q, nq_q[NumW-1]};
  assign div_ge    = rem_shift >= {1'b0, guess_q};
  assign rem_sub   = rem_shift - {1'b0, guess_q};

  // Newton update: (guess + quotient) / 2
  assign step_sum   = (NumW+1)'(guess_q) + {1'b0, nq_q};
  assign next_guess = step_sum[NumW:1];
  assign converged  = next_guess >= NumW'(guess_q);
  assign iter_last  = iter_q == IterW'(MAX_ITERATIONS - 1);

  // Saturate the guess into the 32-bit root
  assign guess_ext = ExtW'(guess_q);
  assign root_sat  = (guess_ext > ExtW'({RootWidth{1'b1}})) ? {RootWidth{1'b1}}
                                                            : guess_ext[RootWidth-1:0];

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = rad_small ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_STEP;
      end
      ST_STEP: begin
        if (converged || iter_last) state_d = ST_OUT;
        else                        state_d = ST_DIV;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic
  always_comb begin
    in_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_DIV, ST_STEP, ST_OUT: in_i.ready = 1'b0;
      default: in_i.ready = 1'b0;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.root  = root_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rad_q   <= in_i.radicand;
          guess_q <= {in_i.radicand, {FRACTION_BITS{1'b0}}};
          rem_q   <= '0;
          nq_q    <= {in_i.radicand, {(2 * FRACTION_BITS){1'b0}}};
          cnt_q   <= CntW'(NumW - 1);
          iter_q  <= '0;
        end
      end
      ST_DIV: begin
        rem_q <= div_ge ? rem_sub[GuessW-1:0] : rem_shift[GuessW-1:0];
        nq_q  <= {nq_q[NumW-2:0], div_ge};
        cnt_q <= cnt_q - CntW'(1);
      end
      ST_STEP: begin
        // Reload the divider for the next step
        rem_q <= '0;
        nq_q  <= {rad_q, {(2 * FRACTION_BITS){1'b0}}};
        cnt_q <= CntW'(NumW - 1);
        if (!converged) begin
          guess_q <= next_guess[GuessW-1:0];
          iter_q  <= iter_q + IterW'(1);
        end
      end
      ST_OUT: begin
        if (out_free) root_q <= root_sat;
      end
      default: ;
    endcase
  end

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> guess_q != '0)
    else $error("divider running with zero guess");

  a_guess_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && state_d == ST_DIV) |=> guess_q < $past(guess_q))
    else $error("Newton step continued without lowering the guess");

  a_step_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP |=> state_q != ST_STEP)
    else $error("update state held for more than one cycle");

endmodule

// ===== dv/nsr_checker.sv =====
// Checker for the square root block: watches both channels, predicts roots and compares.
`timescale 1ns / 1ps

module nsr_checker (
  input  logic clk_i,
  input  logic rst_ni,
  nsr_in_if    in_mon,
  nsr_out_if   out_mon,
  output int   mismatch_count_o,
  output int   roots_pending_o,
  output int   roots_checked_o
);

  import nsr_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned MaxSteps = 32;

  typedef logic [127:0] wide_t;

  typedef struct {
    logic [31:0]          radicand;
    logic [RootWidth-1:0] root;
  } root_req_t;

  root_req_t expected_roots[$];

  // Newton-Raphson root in Q16.16, exact 128-bit intermediates
  function automatic logic [RootWidth-1:0] newton_root(input logic [31:0] radicand);
    wide_t guess;
    wide_t numer;
    wide_t next_guess;
    bit    settled;
    guess   = wide_t'(radicand) << FracBits;
    settled = 1'b0;
    if (radicand >= 2) begin
      numer = wide_t'(radicand) << (2 * FracBits);
      for (int step = 0; step < MaxSteps && !settled; step++) begin
        next_guess = (guess + numer / guess) >> 1;
        // keep the lower guess once a step stops shrinking it
        if (next_guess >= guess) settled = 1'b1;
        else guess = next_guess;
      end
    end
    if (guess > wide_t'({RootWidth{1'b1}})) return '1;
    return guess[RootWidth-1:0];
  endfunction

  // Pop before push: a result never belongs to a request taken on the same edge
  always @(posedge clk_i) begin
    root_req_t head;
    root_req_t req;
    if (!rst_ni) begin
      mismatch_count_o = 0;
      roots_pending_o  = 0;
      roots_checked_o  = 0;
      expected_roots.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_roots.size() == 0) begin
          $error("root: unexpected result 0x%08h with no request waiting", out_mon.root);
          mismatch_count_o++;
        end else begin
          head = expected_roots.pop_front();
          roots_checked_o++;
          if (out_mon.root !== head.root) begin
            $error("root mismatch for radicand 0x%08h: expected 0x%08h actual 0x%08h",
                   head.radicand, head.root, out_mon.root);
            mismatch_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        req.radicand = in_mon.radicand;
        req.root     = newton_root(in_mon.radicand);
        expected_roots.push_back(req);
      end
      roots_pending_o = expected_roots.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the square root block: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int LongHold    = 6000;
  localparam int DrainCycles = 200;
  localparam int RandomItems = 500;
  localparam int CycleLimit  = 8_000_000;

  logic clk_i;
  logic rst_ni;

  int mismatch_count;
  int roots_pending;
  int roots_checked;

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int items_sent;
  int directed_count;
  int cycle_count = 0;

  nsr_in_if #(.InputWidth(32)) in_if ();
  nsr_out_if                   out_if ();

  newton_square_root dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  nsr_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_if),
    .out_mon          (out_if),
    .mismatch_count_o (mismatch_count),
    .roots_pending_o  (roots_pending),
    .roots_checked_o  (roots_checked)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Mix of full-range, small, near-square, trivial and right-shifted radicands
  function automatic logic [31:0] random_radicand();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom;
    if (pick < 65) return $urandom_range(255, 2);
    if (pick < 75) begin
      k = $urandom_range(65535);
      return k * k + $urandom_range(2) - 1;
    end
    if (pick < 85) return $urandom_range(1);
    return $urandom >> $urandom_range(31);
  endfunction

  // Offer one radicand; called at a falling edge, returns at a falling edge
  task automatic send_radicand(input logic [31:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid    = 1'b0;
      in_if.radicand = $urandom;
      @(negedge clk_i);
    end
    in_if.valid    = 1'b1;
    in_if.radicand = value;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (roots_pending != 0) @(negedge clk_i);
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (count) send_radicand(random_radicand());
    wait_drained();
  endtask

  logic [31:0] directed_vals[] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004,
    32'h0000_0009, 32'h0000_00FF, 32'h0001_0000, 32'h0000_FFFF, 32'hFFFE_0001,
    32'hFFFE_0000, 32'hFFFE_0002, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
    32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h4000_0000, 32'h0000_0010,
    32'h00FF_FFFF, 32'h1234_5678
  };

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.radicand  = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_requests   = 0;
    items_sent      = 0;
    directed_count  = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: trivial radicands, perfect squares and their neighbors, extremes
    foreach (directed_vals[i]) send_radicand(directed_vals[i]);
    directed_count = items_sent;
    wait_drained();

    // Random phases over the sender idle and receiver stall mixes
    random_phase(0, 0, RandomItems / 4);
    random_phase(62, 0, RandomItems / 4);
    random_phase(0, 62, RandomItems / 4);
    random_phase(14, 14, RandomItems / 4);

    // Long result hold-off while requests keep coming, so the input backs up
    sender_idle_pct = 0;
    recv_stall_pct  = 30;
    hold_requests++;
    repeat (8) send_radicand(random_radicand());
    wait_drained();

    repeat (DrainCycles) @(negedge clk_i);
    if (roots_pending != 0) $error("root: %0d results never arrived", roots_pending);

    $display("Run covered %0d radicands (%0d directed), %0d roots checked,", items_sent,
             directed_count, roots_checked);
    $display("four idle mixes and one long result hold-off with input back-pressure.");
    if (mismatch_count == 0 && roots_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/nsr_pkg.sv
rtl/core/nsr_in_if.sv
rtl/core/nsr_out_if.sv
rtl/core/newton_square_root.sv
dv/nsr_checker.sv
dv/tb_top.sv
